// ===== hw/rtl/all_pairs_shortest_path_core_defines.svh =====
// ----------------------------------------------------------------------------
// All-pairs shortest path core: assertion macros
// Concurrent check wrappers, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ALL_PAIRS_SHORTEST_PATH_CORE_DEFINES_SVH
`define ALL_PAIRS_SHORTEST_PATH_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define APSP_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("apsp check failed");
`define APSP_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("apsp check failed");
`else
`define APSP_ASSERT_NOW(lbl, clk, rst_n, pre, post)
`define APSP_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// ===== hw/rtl/apsp_pkg.sv =====
// ----------------------------------------------------------------------------
// APSP package
// Sizes, entry types and saturating relaxation shared by the core and cells.
// ----------------------------------------------------------------------------
`default_nettype none
package apsp_pkg;
    localparam int MAXV   = 32;
    localparam int WB     = 16;
    localparam int IW     = $clog2(MAXV);
    localparam int VW     = $clog2(MAXV + 1);
    localparam int CFG_W  = 6;
    localparam int DW     = 32;

    localparam logic [1:0] CMD_ADD     = 2'd0;
    localparam logic [1:0] CMD_CLEAR   = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;
    localparam logic [1:0] CMD_READ    = 2'd3;

    localparam logic signed [DW-1:0] DIST_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] DIST_MIN = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        logic                 ok;
        logic signed [DW-1:0] val;
    } dent_t;

    typedef struct packed {
        logic                 ok;
        logic signed [WB-1:0] w;
    } eent_t;

    typedef dent_t [MAXV-1:0] dist_row_t;
    typedef eent_t [MAXV-1:0] edge_row_t;

    function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1])
            return s[DW] ? DIST_MIN : DIST_MAX;
        return s[DW-1:0];
    endfunction

    // old relaxed by path x then y
    function automatic dent_t relax(input dent_t old, input dent_t x, input dent_t y);
        dent_t                r;
        logic signed [DW-1:0] s;
        r = old;
        s = sat_add(x.val, y.val);
        if (x.ok && y.ok && (!old.ok || s < old.val))
        begin
            r.ok  = 1'b1;
            r.val = s;
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/apsp_cell.sv =====
// ----------------------------------------------------------------------------
// APSP cell
// Holds one column of the pivot row, relaxes one entry, shifts toward cell 0.
// ----------------------------------------------------------------------------
`default_nettype none
module apsp_cell (
    input  wire logic           clk,
    input  wire logic           load_en,
    input  wire logic           load_own,
    input  wire apsp_pkg::dent_t load_val,
    input  wire logic           shift_en,
    input  wire apsp_pkg::dent_t shift_in,
    input  wire apsp_pkg::dent_t ik_old,
    input  wire apsp_pkg::dent_t ik_new,
    input  wire logic           after_k,
    input  wire apsp_pkg::dent_t old_ij,
    output apsp_pkg::dent_t     held,
    output apsp_pkg::dent_t     upd
);
    apsp_pkg::dent_t held_reg;
    apsp_pkg::dent_t x;

    assign x    = after_k ? ik_new : ik_old;
    assign upd  = apsp_pkg::relax(old_ij, x, held_reg);
    assign held = held_reg;

    always_ff @(posedge clk)
    begin
        if (load_own)
            held_reg <= upd;
        else if (load_en)
            held_reg <= load_val;
        else if (shift_en)
            held_reg <= shift_in;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/all_pairs_shortest_path_core.sv =====
// ----------------------------------------------------------------------------
// All-pairs shortest path core
// Edge store, Floyd-Warshall compute over a row of cells, row readout.
// ----------------------------------------------------------------------------
// Commands are taken when start is high and busy is low; each result word is
// shown for one cycle with done and cannot be held off. Compute first writes
// each distance row from its edge row; then each pivot row is loaded into the
// cells, and every source row is read, its pivot term formed, and relaxed
// across all cells at once. A row read loads the row into the cells, then
// gives V words on consecutive cycles shifted out of the cell chain. Stores
// are row-wide memories with per-row valid flags, so reset and clear edges
// take effect at once.
`default_nettype none
`include "all_pairs_shortest_path_core_defines.svh"
module all_pairs_shortest_path_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  command,
    input  wire logic [4:0]  from_vertex,
    input  wire logic [4:0]  to_vertex,
    input  wire logic [15:0] weight,
    input  wire logic        cfg_write,
    input  wire logic [5:0]  cfg_data,
    output logic             done,
    output logic             status,
    output logic [4:0]       dest_vertex,
    output logic [31:0]      distance,
    output logic             reachable,
    output logic             last
);
    localparam int MAXV = apsp_pkg::MAXV;
    localparam int IW   = apsp_pkg::IW;
    localparam int VW   = apsp_pkg::VW;
    localparam int WB   = apsp_pkg::WB;
    localparam int DW   = apsp_pkg::DW;

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_ADD_RD  = 13'b0000000000010,
        S_ADD_WR  = 13'b0000000000100,
        S_INIT_RD = 13'b0000000001000,
        S_INIT_WR = 13'b0000000010000,
        S_K_RD    = 13'b0000000100000,
        S_K_LD    = 13'b0000001000000,
        S_I_RD    = 13'b0000010000000,
        S_I_IK    = 13'b0000100000000,
        S_I_WR    = 13'b0001000000000,
        S_RD_RD   = 13'b0010000000000,
        S_RD_LD   = 13'b0100000000000,
        S_RD_OUT  = 13'b1000000000000
    } state_t;

    state_t                       state_reg, state_next;
    logic [apsp_pkg::CFG_W-1:0]   vc_reg, vc_next;
    logic [VW-1:0]                v_reg, v_next, v_act, v_m1;
    logic [IW-1:0]                from_reg, from_next, to_reg, to_next;
    logic [IW-1:0]                i_reg, i_next, k_reg, k_next;
    logic signed [WB-1:0]         w_reg, w_next;
    logic [MAXV-1:0]              edge_ok_reg, edge_ok_next, dist_ok_reg, dist_ok_next;
    apsp_pkg::dent_t              ik_reg, ik_next, ikn_reg, ikn_next;
    logic                         done_reg, done_next;
    logic                         status_reg, status_next, reach_reg, reach_next;
    logic                         last_reg, last_next;
    logic [4:0]                   dest_reg, dest_next;
    logic [DW-1:0]                distance_reg, distance_next;

    apsp_pkg::edge_row_t          edge_mem [MAXV];
    apsp_pkg::dist_row_t          dist_mem [MAXV];
    apsp_pkg::edge_row_t          edge_q_reg, edge_wdata, edge_row;
    apsp_pkg::dist_row_t          dist_q_reg, dist_wdata, init_row, dist_row;
    logic                         edge_qv_reg, dist_qv_reg, edge_we, dist_we;
    logic [IW-1:0]                edge_raddr, dist_raddr, edge_waddr;

    apsp_pkg::dist_row_t          cell_held, cell_upd;
    logic                         cell_load, cell_load_own, cell_shift;
    logic                         last_i, last_k;
    apsp_pkg::eent_t              ent;

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign dest_vertex = dest_reg;
    assign distance    = distance_reg;
    assign reachable   = reach_reg;
    assign last        = last_reg;

    assign v_act  = (vc_reg == '0) ? VW'(1) :
                    (VW'(vc_reg) > VW'(MAXV)) ? VW'(MAXV) : VW'(vc_reg);
    assign v_m1   = v_reg - VW'(1);
    assign last_i = (VW'(i_reg) == v_m1);
    assign last_k = (VW'(k_reg) == v_m1);

    assign edge_row = edge_qv_reg ? edge_q_reg : '0;
    assign dist_row = dist_qv_reg ? dist_q_reg : '0;

    // memories
    always_ff @(posedge clk)
    begin
        edge_q_reg  <= edge_mem[edge_raddr];
        edge_qv_reg <= edge_ok_reg[edge_raddr];
        dist_q_reg  <= dist_mem[dist_raddr];
        dist_qv_reg <= dist_ok_reg[dist_raddr];
        if (edge_we)
            edge_mem[edge_waddr] <= edge_wdata;
        if (dist_we)
            dist_mem[i_reg] <= dist_wdata;
    end

    always_comb
    begin
        edge_raddr = (state_reg == S_ADD_RD) ? from_reg : i_reg;
        case (state_reg)
            S_K_RD:  dist_raddr = k_reg;
            S_RD_RD: dist_raddr = from_reg;
            default: dist_raddr = i_reg;
        endcase
    end

    // initial distance row from edge row i
    always_comb
    begin
        for (int j = 0; j < MAXV; j++)
        begin
            init_row[j] = '0;
            if (VW'(j) < v_reg)
            begin
                if (IW'(j) == i_reg)
                begin
                    init_row[j].ok = 1'b1;
                    if (edge_row[j].ok && edge_row[j].w < 0)
                        init_row[j].val = DW'(edge_row[j].w);
                end
                else if (edge_row[j].ok)
                begin
                    init_row[j].ok  = 1'b1;
                    init_row[j].val = DW'(edge_row[j].w);
                end
            end
        end
    end

    // cell chain
    for (genvar j = 0; j < MAXV; j++)
    begin : g_cell
        apsp_pkg::dent_t sh_in;
        if (j == MAXV - 1)
        begin : g_end
            assign sh_in = '0;
        end
        else
        begin : g_mid
            assign sh_in = cell_held[j+1];
        end
        apsp_cell u_cell (
            .clk      (clk),
            .load_en  (cell_load),
            .load_own (cell_load_own),
            .load_val (dist_row[j]),
            .shift_en (cell_shift),
            .shift_in (sh_in),
            .ik_old   (ik_reg),
            .ik_new   (ikn_reg),
            .after_k  (IW'(j) > k_reg),
            .old_ij   (dist_q_reg[j]),
            .held     (cell_held[j]),
            .upd      (cell_upd[j])
        );
    end

    always_comb
    begin
        state_next    = state_reg;
        vc_next       = cfg_write ? cfg_data : vc_reg;
        v_next        = v_reg;
        from_next     = from_reg;
        to_next       = to_reg;
        w_next        = w_reg;
        i_next        = i_reg;
        k_next        = k_reg;
        edge_ok_next  = edge_ok_reg;
        dist_ok_next  = dist_ok_reg;
        ik_next       = ik_reg;
        ikn_next      = ikn_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        dest_next     = dest_reg;
        distance_next = distance_reg;
        reach_next    = reach_reg;
        last_next     = last_reg;
        edge_we       = 1'b0;
        edge_waddr    = from_reg;
        edge_wdata    = edge_row;
        dist_we       = 1'b0;
        dist_wdata    = init_row;
        cell_load     = 1'b0;
        cell_load_own = 1'b0;
        cell_shift    = 1'b0;
        ent           = edge_row[to_reg];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    from_next     = from_vertex;
                    to_next       = to_vertex;
                    w_next        = weight[WB-1:0];
                    v_next        = v_act;
                    i_next        = '0;
                    k_next        = '0;
                    status_next   = 1'b0;
                    dest_next     = '0;
                    distance_next = '0;
                    reach_next    = 1'b0;
                    last_next     = 1'b1;
                    case (command)
                        apsp_pkg::CMD_ADD:
                        begin
                            if (VW'(from_vertex) >= v_act || VW'(to_vertex) >= v_act)
                            begin
                                done_next   = 1'b1;
                                status_next = 1'b1;
                            end
                            else
                                state_next = S_ADD_RD;
                        end
                        apsp_pkg::CMD_CLEAR:
                        begin
                            edge_ok_next = '0;
                            done_next    = 1'b1;
                        end
                        apsp_pkg::CMD_COMPUTE:
                        begin
                            dist_ok_next = '0;
                            state_next   = S_INIT_RD;
                        end
                        apsp_pkg::CMD_READ:
                        begin
                            if (VW'(from_vertex) >= v_act)
                            begin
                                done_next   = 1'b1;
                                status_next = 1'b1;
                            end
                            else
                                state_next = S_RD_RD;
                        end
                        default:
                            done_next = 1'b1;
                    endcase
                end
            end
            S_ADD_RD:
                state_next = S_ADD_WR;
            S_ADD_WR:
            begin
                if (!ent.ok || w_reg < ent.w)
                begin
                    edge_wdata[to_reg].ok = 1'b1;
                    edge_wdata[to_reg].w  = w_reg;
                end
                edge_we                = 1'b1;
                edge_ok_next[from_reg] = 1'b1;
                done_next              = 1'b1;
                state_next             = S_IDLE;
            end
            S_INIT_RD:
                state_next = S_INIT_WR;
            S_INIT_WR:
            begin
                dist_we             = 1'b1;
                dist_ok_next[i_reg] = 1'b1;
                if (last_i)
                begin
                    i_next     = '0;
                    state_next = S_K_RD;
                end
                else
                begin
                    i_next     = i_reg + IW'(1);
                    state_next = S_INIT_RD;
                end
            end
            S_K_RD:
                state_next = S_K_LD;
            S_K_LD:
            begin
                cell_load  = 1'b1;
                state_next = S_I_RD;
            end
            S_I_RD:
                state_next = S_I_IK;
            S_I_IK:
            begin
                ik_next    = dist_q_reg[k_reg];
                ikn_next   = apsp_pkg::relax(dist_q_reg[k_reg], dist_q_reg[k_reg],
                                             cell_held[k_reg]);
                state_next = S_I_WR;
            end
            S_I_WR:
            begin
                dist_we    = 1'b1;
                dist_wdata = cell_upd;
                if (i_reg == k_reg)
                    cell_load_own = 1'b1;
                if (last_i)
                begin
                    i_next = '0;
                    if (last_k)
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + IW'(1);
                        state_next = S_K_RD;
                    end
                end
                else
                begin
                    i_next     = i_reg + IW'(1);
                    state_next = S_I_RD;
                end
            end
            S_RD_RD:
                state_next = S_RD_LD;
            S_RD_LD:
            begin
                cell_load  = 1'b1;
                state_next = S_RD_OUT;
            end
            S_RD_OUT:
            begin
                cell_shift    = 1'b1;
                done_next     = 1'b1;
                dest_next     = 5'(i_reg);
                reach_next    = cell_held[0].ok;
                distance_next = cell_held[0].ok ? cell_held[0].val : '0;
                last_next     = last_i;
                if (last_i)
                    state_next = S_IDLE;
                else
                    i_next = i_reg + IW'(1);
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            vc_reg      <= apsp_pkg::CFG_W'(MAXV);
            edge_ok_reg <= '0;
            dist_ok_reg <= '0;
            done_reg    <= 1'b0;
            i_reg       <= '0;
            k_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            vc_reg      <= vc_next;
            edge_ok_reg <= edge_ok_next;
            dist_ok_reg <= dist_ok_next;
            done_reg    <= done_next;
            i_reg       <= i_next;
            k_reg       <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg        <= v_next;
        from_reg     <= from_next;
        to_reg       <= to_next;
        w_reg        <= w_next;
        ik_reg       <= ik_next;
        ikn_reg      <= ikn_next;
        status_reg   <= status_next;
        dest_reg     <= dest_next;
        distance_reg <= distance_next;
        reach_reg    <= reach_next;
        last_reg     <= last_next;
    end

    `APSP_ASSERT_NEXT(a_row_words_back_to_back, clk, rst_n, done && !last, done)
    `APSP_ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, busy || done)
    `APSP_ASSERT_NOW(a_error_word, clk, rst_n, done && status, last && !reachable)
    `APSP_ASSERT_NOW(a_finish_with_last, clk, rst_n, $fell(busy), done && last)
endmodule
`default_nettype wire

// ===== verif/all_pairs_shortest_path_core_tb.sv =====
// ----------------------------------------------------------------------------
// All-pairs shortest path core testbench
// Drives add/clear/compute/read commands over several vertex counts and idle
// patterns, predicts every result word and compares each one with the word it predicts.
// ----------------------------------------------------------------------------
`default_nettype none
module all_pairs_shortest_path_core_tb;
    localparam int LIMIT  = 4000000;
    localparam int QDEPTH = 1024;
    localparam int NROWS  = 14;

    typedef struct packed {
        logic        status;
        logic [4:0]  dest;
        logic [31:0] dval;
        logic        reach;
        logic        last;
    } word_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [4:0]  from;
        logic [4:0]  to;
        logic [15:0] w;
        logic        has_exp;
        word_t       exp;
    } stim_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  command = '0;
    logic [4:0]  from_vertex = '0;
    logic [4:0]  to_vertex = '0;
    logic [15:0] weight = '0;
    logic        cfg_write = 1'b0;
    logic [5:0]  cfg_data = '0;
    logic        done;
    logic        status;
    logic [4:0]  dest_vertex;
    logic [31:0] distance;
    logic        reachable;
    logic        last;

    all_pairs_shortest_path_core uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .from_vertex(from_vertex), .to_vertex(to_vertex),
        .weight(weight), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .done(done), .status(status), .dest_vertex(dest_vertex),
        .distance(distance), .reachable(reachable), .last(last)
    );

    always #6 clk = ~clk;

    // predictor state
    logic [5:0]          vcount;
    bit                  edge_ok [apsp_pkg::MAXV][apsp_pkg::MAXV];
    logic signed [15:0]  edge_w  [apsp_pkg::MAXV][apsp_pkg::MAXV];
    bit                  path_ok [apsp_pkg::MAXV][apsp_pkg::MAXV];
    longint              path_len[apsp_pkg::MAXV][apsp_pkg::MAXV];

    // expected words, ring indexed by running counts
    word_t  exp_q [QDEPTH];
    int     q_wr = 0;
    int     q_rd = 0;
    int     errors = 0;
    int     cycles = 0;
    int     idle_pct = 0;

    function automatic void put_word(word_t w);
        exp_q[q_wr % QDEPTH] = w;
        q_wr++;
    endfunction

    function automatic int active_v();
        if (vcount < 1) return 1;
        if (vcount > apsp_pkg::MAXV) return apsp_pkg::MAXV;
        return vcount;
    endfunction

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic word_t ack_word(logic st);
        word_t r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic run_floyd_warshall();
        int     v;
        longint s;
        v = active_v();
        for (int i = 0; i < apsp_pkg::MAXV; i++)
            for (int j = 0; j < apsp_pkg::MAXV; j++)
            begin
                path_ok[i][j] = 0;
                path_len[i][j] = 0;
            end
        for (int i = 0; i < v; i++)
            for (int j = 0; j < v; j++)
                if (i == j)
                begin
                    path_ok[i][j] = 1;
                    if (edge_ok[i][j] && edge_w[i][j] < 0) path_len[i][j] = edge_w[i][j];
                end
                else if (edge_ok[i][j])
                begin
                    path_ok[i][j] = 1;
                    path_len[i][j] = edge_w[i][j];
                end
        for (int k = 0; k < v; k++)
            for (int i = 0; i < v; i++)
            begin
                if (!path_ok[i][k]) continue;
                for (int j = 0; j < v; j++)
                begin
                    if (!path_ok[k][j]) continue;
                    s = clamp32(path_len[i][k] + path_len[k][j]);
                    if (!path_ok[i][j] || s < path_len[i][j])
                    begin
                        path_ok[i][j] = 1;
                        path_len[i][j] = s;
                    end
                end
            end
    endtask

    task automatic predict_command(logic [1:0] cmd, logic [4:0] fr, logic [4:0] to,
                                   logic [15:0] w);
        int    v;
        word_t r;
        v = active_v();
        case (cmd)
            apsp_pkg::CMD_ADD:
            begin
                if (fr >= v || to >= v) put_word(ack_word(1'b1));
                else
                begin
                    if (!edge_ok[fr][to] || $signed(w) < edge_w[fr][to])
                    begin
                        edge_ok[fr][to] = 1;
                        edge_w[fr][to] = w;
                    end
                    put_word(ack_word(1'b0));
                end
            end
            apsp_pkg::CMD_CLEAR:
            begin
                for (int i = 0; i < apsp_pkg::MAXV; i++)
                    for (int j = 0; j < apsp_pkg::MAXV; j++) edge_ok[i][j] = 0;
                put_word(ack_word(1'b0));
            end
            apsp_pkg::CMD_COMPUTE:
            begin
                run_floyd_warshall();
                put_word(ack_word(1'b0));
            end
            default:
            begin
                if (fr >= v) put_word(ack_word(1'b1));
                else
                    for (int j = 0; j < v; j++)
                    begin
                        r = '0;
                        r.dest = 5'(j);
                        r.reach = path_ok[fr][j];
                        r.dval = path_ok[fr][j] ? 32'(path_len[fr][j]) : '0;
                        r.last = (j == v - 1);
                        put_word(r);
                    end
            end
        endcase
    endtask

    // result check at rising edge
    always @(posedge clk)
    begin
        word_t got, want;
        cycles <= cycles + 1;
        if (rst_n && done)
        begin
            got = {status, dest_vertex, distance, reachable, last};
            if (q_wr == q_rd)
            begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
            end
            else
            begin
                want = exp_q[q_rd % QDEPTH];
                q_rd++;
                if (got !== want)
                begin
                    $display("%0t: mismatch expected st=%b dst=%0d dist=%0d rch=%b last=%b",
                             $time, want.status, want.dest, $signed(want.dval), want.reach,
                             want.last);
                    $display("%0t:          actual   st=%b dst=%0d dist=%0d rch=%b last=%b",
                             $time, got.status, got.dest, $signed(got.dval), got.reach,
                             got.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // returns at the falling edge after the accept, start still high
    task automatic send(logic [1:0] cmd, logic [4:0] fr, logic [4:0] to, logic [15:0] w);
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        command <= cmd;
        from_vertex <= fr;
        to_vertex <= to;
        weight <= w;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_command(cmd, fr, to, w);
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (q_wr != q_rd) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_vertices(logic [5:0] n);
        drain();
        cfg_data <= n;
        cfg_write <= 1'b1;
        @(negedge clk);
        cfg_write <= 1'b0;
        vcount = n;
    endtask

    // random traffic: mostly add edges, with occasional clear, compute and reads
    task automatic random_batch(int n);
        int v;
        logic [1:0] c;
        logic [4:0] f, t;
        for (int i = 0; i < n; i++)
        begin
            v = active_v();
            case ($urandom_range(19, 0))
                0: c = apsp_pkg::CMD_CLEAR;
                1, 2: c = apsp_pkg::CMD_COMPUTE;
                3, 4, 5: c = apsp_pkg::CMD_READ;
                default: c = apsp_pkg::CMD_ADD;
            endcase
            f = ($urandom_range(9, 0) == 0) ? 5'($urandom) : 5'($urandom_range(v - 1, 0));
            t = ($urandom_range(9, 0) == 0) ? 5'($urandom) : 5'($urandom_range(v - 1, 0));
            if ($urandom_range(3, 0) == 0) send(c, f, t, 16'($urandom));
            else send(c, f, t, 16'($signed($urandom_range(60, 0)) - 16'sd10));
        end
    endtask

    stim_t dir_rows [NROWS];

    initial
    begin
        stim_t s;
        word_t r;
        vcount = 6'd32;
        for (int i = 0; i < apsp_pkg::MAXV; i++)
            for (int j = 0; j < apsp_pkg::MAXV; j++)
            begin
                edge_ok[i][j] = 0;
                edge_w[i][j] = 0;
                path_ok[i][j] = 0;
                path_len[i][j] = 0;
            end
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // read before any compute: all unreachable
        r = '0;
        r.dest = 5'd31;
        r.last = 1'b1;
        dir_rows[0]  = '{apsp_pkg::CMD_READ, 5'd31, 5'd0, 16'h0, 1'b0, r};
        dir_rows[1]  = '{apsp_pkg::CMD_ADD, 5'd0, 5'd31, 16'h7fff, 1'b1, ack_word(1'b0)};
        dir_rows[2]  = '{apsp_pkg::CMD_ADD, 5'd31, 5'd0, 16'h8000, 1'b1, ack_word(1'b0)};
        dir_rows[3]  = '{apsp_pkg::CMD_ADD, 5'd0, 5'd31, 16'h0005, 1'b1, ack_word(1'b0)};
        dir_rows[4]  = '{apsp_pkg::CMD_ADD, 5'd0, 5'd31, 16'h0009, 1'b1, ack_word(1'b0)};
        dir_rows[5]  = '{apsp_pkg::CMD_ADD, 5'd3, 5'd3, 16'hfffd, 1'b1, ack_word(1'b0)};
        dir_rows[6]  = '{apsp_pkg::CMD_ADD, 5'd4, 5'd4, 16'h0007, 1'b1, ack_word(1'b0)};
        dir_rows[7]  = '{apsp_pkg::CMD_ADD, 5'd1, 5'd2, 16'h1234, 1'b1, ack_word(1'b0)};
        dir_rows[8]  = '{apsp_pkg::CMD_COMPUTE, 5'd0, 5'd0, 16'h0, 1'b1, ack_word(1'b0)};
        dir_rows[9]  = '{apsp_pkg::CMD_READ, 5'd0, 5'd0, 16'h0, 1'b0, r};
        dir_rows[10] = '{apsp_pkg::CMD_READ, 5'd3, 5'd0, 16'h0, 1'b0, r};
        dir_rows[11] = '{apsp_pkg::CMD_READ, 5'd31, 5'd0, 16'h0, 1'b0, r};
        dir_rows[12] = '{apsp_pkg::CMD_CLEAR, 5'd0, 5'd0, 16'h0, 1'b1, ack_word(1'b0)};
        dir_rows[13] = '{apsp_pkg::CMD_READ, 5'd1, 5'd0, 16'h0, 1'b0, r};
        foreach (dir_rows[i])
        begin
            s = dir_rows[i];
            send(s.cmd, s.from, s.to, s.w);
            if (s.has_exp && exp_q[(q_wr - 1) % QDEPTH] !== s.exp)
            begin
                $display("%0t: table row %0d expected %h, predicted %h", $time, i, s.exp,
                         exp_q[(q_wr - 1) % QDEPTH]);
                errors++;
            end
        end

        // small graph: out of range, negative cycle saturation
        set_vertices(6'd4);
        send(apsp_pkg::CMD_ADD, 5'd4, 5'd0, 16'h1);
        send(apsp_pkg::CMD_ADD, 5'd0, 5'd31, 16'h1);
        send(apsp_pkg::CMD_READ, 5'd4, 5'd0, 16'h0);
        send(apsp_pkg::CMD_ADD, 5'd0, 5'd1, 16'h8000);
        send(apsp_pkg::CMD_ADD, 5'd1, 5'd0, 16'h8000);
        send(apsp_pkg::CMD_ADD, 5'd2, 5'd3, 16'h7fff);
        send(apsp_pkg::CMD_COMPUTE, 5'd0, 5'd0, 16'h0);
        send(apsp_pkg::CMD_READ, 5'd0, 5'd0, 16'h0);
        send(apsp_pkg::CMD_READ, 5'd2, 5'd0, 16'h0);

        set_vertices(6'd0);
        send(apsp_pkg::CMD_ADD, 5'd0, 5'd0, 16'hffff);
        send(apsp_pkg::CMD_COMPUTE, 5'd0, 5'd0, 16'h0);
        send(apsp_pkg::CMD_READ, 5'd0, 5'd0, 16'h0);
        send(apsp_pkg::CMD_READ, 5'd1, 5'd0, 16'h0);

        idle_pct = 0;
        set_vertices(6'd5);
        random_batch(80);
        idle_pct = 63;
        set_vertices(6'd1);
        random_batch(40);
        drain();
        idle_pct = 31;
        set_vertices(6'd63);
        random_batch(60);
        idle_pct = 0;
        set_vertices(6'd8);
        random_batch(120);
        idle_pct = 63;
        set_vertices(6'd32);
        random_batch(50);
        idle_pct = 31;
        set_vertices(6'd3);
        random_batch(70);

        drain();
        repeat (40) @(negedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
